// File: design/ddcr_pkg.sv
// ----------------------------------------------------------------------------
// ddcr_pkg
// Types, constants and table generator shared by the delay-Doppler residual
// unit and its submodules.
// ----------------------------------------------------------------------------
package ddcr_pkg;

  // opcodes of an input item
  localparam logic OpLoad  = 1'b0;
  localparam logic OpPilot = 1'b1;

  // pilots at or above this index give no result
  localparam int MaxPilots = 256;

  // 2*pi in Q40 and one in Q30 for the table generator
  localparam longint TwoPiQ40 = 64'sd6908435304715;
  localparam longint Q30One   = 64'sd1073741824;

  // magnitude root: 40-bit radicand, two result bits per cycle
  localparam int RootInW  = 40;
  localparam int RootOutW = 21;
  localparam int RootSteps = RootInW / 4;
  localparam int ResW = 20;
  localparam logic [ResW-1:0] ResMax = '1;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  path_index;
    logic signed [23:0] delay;
    logic signed [23:0] doppler;
    logic signed [15:0] gain_re;
    logic signed [15:0] gain_im;
    logic [7:0]  pilot_index;
    logic [7:0]  pilot_m;
    logic [7:0]  pilot_n;
    logic signed [15:0] observed_re;
    logic signed [15:0] observed_im;
  } in_item_t;

  typedef struct packed {
    logic [19:0] residual;
    logic [7:0]  residual_index;
  } out_item_t;

  // one stored path entry
  typedef struct packed {
    logic signed [23:0] delay;
    logic signed [23:0] doppler;
    logic signed [15:0] gain_re;
    logic signed [15:0] gain_im;
  } path_t;

  // Q1.14 cosine (upper half) and sine (lower half) of 2*pi*a/2^pb,
  // for a within the first octant, by an eight-term series in Q30
  function automatic logic [31:0] oct_cs(input int a, input int pb);
    longint x;
    longint x2;
    longint ts;
    longint tc;
    longint sv;
    longint cv;
    longint c;
    longint s;
    x  = (longint'(a) * TwoPiQ40 + (longint'(1) <<< (pb + 9))) >>> (pb + 10);
    x2 = (x * x) >>> 30;
    ts = x;
    tc = Q30One;
    sv = x;
    cv = Q30One;
    ts = ((ts * x2) >>> 30) / 6;   tc = ((tc * x2) >>> 30) / 2;
    sv = sv - ts;                  cv = cv - tc;
    ts = ((ts * x2) >>> 30) / 20;  tc = ((tc * x2) >>> 30) / 12;
    sv = sv + ts;                  cv = cv + tc;
    ts = ((ts * x2) >>> 30) / 42;  tc = ((tc * x2) >>> 30) / 30;
    sv = sv - ts;                  cv = cv - tc;
    ts = ((ts * x2) >>> 30) / 72;  tc = ((tc * x2) >>> 30) / 56;
    sv = sv + ts;                  cv = cv + tc;
    ts = ((ts * x2) >>> 30) / 110; tc = ((tc * x2) >>> 30) / 90;
    sv = sv - ts;                  cv = cv - tc;
    ts = ((ts * x2) >>> 30) / 156; tc = ((tc * x2) >>> 30) / 132;
    sv = sv + ts;                  cv = cv + tc;
    ts = ((ts * x2) >>> 30) / 210; tc = ((tc * x2) >>> 30) / 182;
    sv = sv - ts;                  cv = cv - tc;
    if (sv < 0) sv = 0;
    if (cv < 0) cv = 0;
    c = (cv + 64'sd32768) >>> 16;
    s = (sv + 64'sd32768) >>> 16;
    return {c[15:0], s[15:0]};
  endfunction

endpackage

// File: design/ddcr_cell.sv
// ----------------------------------------------------------------------------
// ddcr_cell
// One path entry of the path ring: written by a load item, passed on to its
// neighbor in every cycle of a pilot sweep.
// ----------------------------------------------------------------------------
module ddcr_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  ddcr_pkg::path_t load_data_i,
  input  logic            shift_i,
  input  ddcr_pkg::path_t next_i,
  output ddcr_pkg::path_t path_o
);

  ddcr_pkg::path_t path_q;

  // entry storage, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      path_q <= load_data_i;
    end else if (shift_i) begin
      path_q <= next_i;
    end
  end

  assign path_o = path_q;

endmodule

// File: design/ddcr_trig.sv
// ----------------------------------------------------------------------------
// ddcr_trig
// Cosine and sine lookup from an octant table with quadrant folding.
// ----------------------------------------------------------------------------
module ddcr_trig #(
  parameter int PhaseBits = 10
) (
  input  logic [PhaseBits-1:0] phase_i,
  output logic signed [15:0]   cos_o,
  output logic signed [15:0]   sin_o
);

  localparam int IdxW    = PhaseBits - 2;
  localparam int Quarter = 1 << IdxW;
  localparam int OctN    = Quarter / 2 + 1;

  logic [31:0] oct_tab [OctN];

  // constant octant table
  for (genvar g = 0; g < OctN; g++) begin : g_tab
    localparam logic [31:0] Entry = ddcr_pkg::oct_cs(g, PhaseBits);
    assign oct_tab[g] = Entry;
  end

  logic [1:0]      quad;
  logic [IdxW-1:0] frac;
  logic [IdxW:0]   mirror;
  logic            fold;
  logic [IdxW-1:0] idx;
  logic signed [15:0] c0;
  logic signed [15:0] s0;

  assign quad   = phase_i[PhaseBits-1 -: 2];
  assign frac   = phase_i[IdxW-1:0];
  assign mirror = (IdxW+1)'(Quarter) - {1'b0, frac};
  assign fold   = {1'b0, frac} > (IdxW+1)'(Quarter / 2);
  assign idx    = fold ? mirror[IdxW-1:0] : frac;

  // swap in the upper octant, then rotate by quadrant
  always_comb begin
    if (fold) begin
      c0 = oct_tab[idx][15:0];
      s0 = oct_tab[idx][31:16];
    end else begin
      c0 = oct_tab[idx][31:16];
      s0 = oct_tab[idx][15:0];
    end
    case (quad)
      2'd1: begin
        cos_o = -s0;
        sin_o = c0;
      end
      2'd2: begin
        cos_o = -c0;
        sin_o = -s0;
      end
      2'd3: begin
        cos_o = s0;
        sin_o = -c0;
      end
      default: begin
        cos_o = c0;
        sin_o = s0;
      end
    endcase
  end

endmodule

// File: design/ddcr_root.sv
// ----------------------------------------------------------------------------
// ddcr_root
// Rounded integer square root, two result bits per cycle.
// ----------------------------------------------------------------------------
module ddcr_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ddcr_pkg::RootInW-1:0]  value_i,
  output logic                          done_o,
  output logic [ddcr_pkg::RootOutW-1:0] root_o
);

  localparam int W  = ddcr_pkg::RootInW;
  localparam int CW = $clog2(ddcr_pkg::RootSteps);

  logic [W-1:0]  rem_q, rem_d;
  logic [W:0]    r_q, r_d;
  logic [W-1:0]  bit_q, bit_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  // two restoring steps
  always_comb begin
    rem_d = rem_q;
    r_d   = r_q;
    bit_d = bit_q;
    for (int i = 0; i < 2; i++) begin
      if ({1'b0, rem_d} >= r_d + {1'b0, bit_d}) begin
        rem_d = W'({1'b0, rem_d} - r_d - {1'b0, bit_d});
        r_d   = (r_d >> 1) + {1'b0, bit_d};
      end else begin
        r_d = r_d >> 1;
      end
      bit_d = bit_d >> 2;
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ddcr_pkg::RootSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      r_q   <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      rem_q <= rem_d;
      r_q   <= r_d;
      bit_q <= bit_d;
    end
  end

  // round to nearest
  assign done_o = done_q;
  assign root_o = ({1'b0, rem_q} > r_q) ? ddcr_pkg::RootOutW'(r_q + 1'b1)
                                        : ddcr_pkg::RootOutW'(r_q);

endmodule

// File: design/delay_doppler_channel_residual_unit.sv
// ----------------------------------------------------------------------------
// delay_doppler_channel_residual_unit
// Load item: written into the path ring when it is accepted.
// Pilot item: a sweep of the path ring over all MAX_PATHS entries, a drain of
// the product pipeline, difference, square, the square root, then the result.
// One pilot at a time; a new item is taken while the result waits.
// Reset clears control and sets path_count to 1; path entries stay undefined.
// ----------------------------------------------------------------------------
module delay_doppler_channel_residual_unit #(
  parameter int MAX_PATHS  = 8,
  parameter int PHASE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ddcr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ddcr_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_data_i
);

  localparam int TW   = $clog2(MAX_PATHS) + 1;
  localparam int AccW = 34 + $clog2(MAX_PATHS);
  localparam int DW   = AccW - 13;
  localparam int SW   = 2 * DW;
  localparam int RW   = ddcr_pkg::RootInW;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ROTATE = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_DIFF   = 7'b0001000,
    ST_SQUARE = 7'b0010000,
    ST_ROOT   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic       in_acc;
  logic       load_acc;
  logic       pilot_acc;
  logic [3:0] path_count_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign load_acc    = in_acc & (in_data_i.opcode == ddcr_pkg::OpLoad);
  assign pilot_acc   = in_acc & (in_data_i.opcode == ddcr_pkg::OpPilot)
                     & ({1'b0, in_data_i.pilot_index} < 9'(ddcr_pkg::MaxPilots));

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_count_q <= 4'd1;
    end else if (cfg_valid_i) begin
      path_count_q <= cfg_data_i;
    end
  end

  // path ring
  ddcr_pkg::path_t load_path;
  ddcr_pkg::path_t ring [MAX_PATHS];
  logic            shift;

  assign load_path = '{delay:   in_data_i.delay,   doppler: in_data_i.doppler,
                       gain_re: in_data_i.gain_re, gain_im: in_data_i.gain_im};
  assign shift = (state_q == ST_ROTATE);

  for (genvar g = 0; g < MAX_PATHS; g++) begin : g_cell
    ddcr_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (load_acc & (int'(in_data_i.path_index) == g)),
      .load_data_i (load_path),
      .shift_i     (shift),
      .next_i      (ring[(g + 1) % MAX_PATHS]),
      .path_o      (ring[g])
    );
  end

  // pilot registers
  logic [8:0]         m2_q, n2_q;
  logic [7:0]         pidx_q;
  logic signed [15:0] ore_q, oim_q;

  always_ff @(posedge clk_i) begin
    if (pilot_acc) begin
      m2_q   <= {in_data_i.pilot_m, 1'b1};
      n2_q   <= {in_data_i.pilot_n, 1'b1};
      pidx_q <= in_data_i.pilot_index;
      ore_q  <= in_data_i.observed_re;
      oim_q  <= in_data_i.observed_im;
    end
  end

  // sweep and drain counters
  logic [TW-1:0] t_q;
  logic [1:0]    drain_q;
  logic          issue;

  assign issue = shift & (int'(t_q) < int'(path_count_q));

  // stage 1: phase modulo one full turn
  logic [25:0] pd_full, pn_full;
  logic [16:0] frac1_q;
  logic signed [15:0] gr1_q, gi1_q;
  logic        v1_q;

  assign pd_full = ring[0].delay[16:0] * m2_q;
  assign pn_full = ring[0].doppler[16:0] * n2_q;

  always_ff @(posedge clk_i) begin
    frac1_q <= pd_full[16:0] - pn_full[16:0];
    gr1_q   <= ring[0].gain_re;
    gi1_q   <= ring[0].gain_im;
  end

  // stage 2: table index and lookup
  logic [17:0]           frac_rnd;
  logic [PHASE_BITS-1:0] k1;
  logic signed [15:0]    cos1, sin1;
  logic signed [15:0]    c2_q, s2_q, gr2_q, gi2_q;
  logic                  v2_q;

  assign frac_rnd = {1'b0, frac1_q} + (18'd1 << (16 - PHASE_BITS));
  assign k1       = frac_rnd[17-PHASE_BITS +: PHASE_BITS];

  ddcr_trig #(.PhaseBits(PHASE_BITS)) u_trig (
    .phase_i (k1),
    .cos_o   (cos1),
    .sin_o   (sin1)
  );

  always_ff @(posedge clk_i) begin
    c2_q  <= cos1;
    s2_q  <= sin1;
    gr2_q <= gr1_q;
    gi2_q <= gi1_q;
  end

  // stage 3: complex product
  logic signed [32:0] pre_d, pim_d, pre_q, pim_q;
  logic               v3_q;

  assign pre_d = gr2_q * c2_q + gi2_q * s2_q;
  assign pim_d = gi2_q * c2_q - gr2_q * s2_q;

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
    pim_q <= pim_d;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 4: accumulate
  logic signed [AccW-1:0] acc_re_q, acc_im_q;

  always_ff @(posedge clk_i) begin
    if (pilot_acc) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v3_q) begin
      acc_re_q <= acc_re_q + {{(AccW-33){pre_q[32]}}, pre_q};
      acc_im_q <= acc_im_q + {{(AccW-33){pim_q[32]}}, pim_q};
    end
  end

  // rounding to Q.14 and difference to the observation
  logic signed [AccW-1:0] rb_re, rb_im;
  logic signed [DW-1:0]   dr_d, di_d, dr_q, di_q;

  assign rb_re = acc_re_q + AccW'(14'h2000);
  assign rb_im = acc_im_q + AccW'(14'h2000);
  assign dr_d  = {rb_re[AccW-1], rb_re[AccW-1:14]} - DW'(ore_q);
  assign di_d  = {rb_im[AccW-1], rb_im[AccW-1:14]} - DW'(oim_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIFF) begin
      dr_q <= dr_d;
      di_q <= di_d;
    end
  end

  // squared magnitude and root
  logic signed [SW-1:0] sq_re, sq_im;
  logic [SW-1:0]        sq;
  logic                 sat_q;
  logic                 root_done;
  logic [ddcr_pkg::RootOutW-1:0] root;

  assign sq_re = dr_q * dr_q;
  assign sq_im = di_q * di_q;
  assign sq    = sq_re + sq_im;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SQUARE) begin
      sat_q <= |sq[SW-1:RW];
    end
  end

  ddcr_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_SQUARE),
    .value_i (sq[RW-1:0]),
    .done_o  (root_done),
    .root_o  (root)
  );

  // saturated result
  logic [ddcr_pkg::ResW-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_ROOT) && root_done) begin
      res_q <= (sat_q || root[ddcr_pkg::RootOutW-1]) ? ddcr_pkg::ResMax
                                                     : root[ddcr_pkg::ResW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pilot_acc) state_d = ST_ROTATE;
      end
      ST_ROTATE: begin
        if (t_q == TW'(MAX_PATHS - 1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_q == 2'd2) state_d = ST_DIFF;
      end
      ST_DIFF:   state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      t_q     <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      t_q     <= (state_q == ST_ROTATE) ? t_q + 1'b1 : '0;
      drain_q <= (state_q == ST_DRAIN) ? drain_q + 1'b1 : '0;
    end
  end

  // output register
  logic out_valid_q;
  ddcr_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
      out_q <= '{residual: res_q, residual_index: pidx_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for delay_doppler_channel_residual_unit. A directed table loads
// every path entry with extreme values and checks pilots at path counts of
// zero, one, eight and fifteen. Random load and pilot items follow under
// several path counts. Results are compared field by field against the
// table's expected values or an in-bench predictor of the residual.
// ----------------------------------------------------------------------------
module tb;
  import ddcr_pkg::*;

  localparam int NumPaths   = 8;
  localparam int PhaseBits  = 10;
  localparam int NumRandom  = 530;
  localparam int CalmItems  = 100;
  localparam int SettleCyc  = 40;
  localparam int NoCfg      = -1;

  // directed stimulus row
  typedef struct {
    int        cfg_before;
    in_item_t  item;
    bit        has_exp;
    out_item_t exp;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [3:0] cfg_data_i = '0;

  // predictor state
  path_t      path_store [NumPaths];
  logic [3:0] path_count_q;
  out_item_t  residual_q [$];

  int  mismatches = 0;
  int  residuals_seen = 0;
  int  loads_sent = 0;
  int  pilots_sent = 0;
  bit  calm = 1'b0;

  delay_doppler_channel_residual_unit #(
    .MAX_PATHS (NumPaths),
    .PHASE_BITS(PhaseBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // first-octant cosine and sine in Q1.14 by an eight-term series in Q30
  function automatic void octant_trig(input longint a, output longint c, output longint s);
    longint x, x2, ts, tc, sv, cv;
    x  = (a * TwoPiQ40 + (longint'(1) <<< (PhaseBits + 9))) >>> (PhaseBits + 10);
    x2 = (x * x) >>> 30;
    ts = x;
    tc = Q30One;
    sv = x;
    cv = Q30One;
    for (int k = 1; k <= 7; k++) begin
      ts = ((ts * x2) >>> 30) / ((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >>> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sv = sv - ts;
        cv = cv - tc;
      end else begin
        sv = sv + ts;
        cv = cv + tc;
      end
    end
    if (sv < 0) sv = 0;
    if (cv < 0) cv = 0;
    c = (cv + 32768) >>> 16;
    s = (sv + 32768) >>> 16;
  endfunction

  // full-circle lookup from the octant by symmetry
  function automatic void phase_trig(input int unsigned idx, output longint c, output longint s);
    int     quarter, quad, j;
    longint c0, s0, t;
    quarter = 1 << (PhaseBits - 2);
    quad = (idx >> (PhaseBits - 2)) & 3;
    j = idx & (quarter - 1);
    if (j <= quarter / 2) octant_trig(j, c0, s0);
    else octant_trig(quarter - j, s0, c0);
    case (quad)
      1: begin
        t = c0; c0 = -s0; s0 = t;
      end
      2: begin
        c0 = -c0; s0 = -s0;
      end
      3: begin
        t = c0; c0 = s0; s0 = -t;
      end
      default: ;
    endcase
    c = c0;
    s = s0;
  endfunction

  // floor((v + 2^13) / 2^14)
  function automatic longint round_to_q14(input longint v);
    longint b;
    b = v + (longint'(1) <<< 13);
    if (b >= 0) return b >>> 14;
    return -(((-b) + (longint'(1) <<< 14) - 1) >>> 14);
  endfunction

  // square root rounded to nearest
  function automatic longint unsigned root_nearest(input longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  // residual of the channel model for one pilot item
  function automatic out_item_t pilot_residual(input in_item_t it);
    out_item_t      r;
    longint         m2, n2, ph, c, s, gr, gi, acc_re, acc_im, dr, di;
    int unsigned    frac, idx, cnt;
    longint unsigned mag;
    m2 = 2 * longint'(it.pilot_m) + 1;
    n2 = 2 * longint'(it.pilot_n) + 1;
    cnt = (path_count_q > NumPaths) ? NumPaths : path_count_q;
    acc_re = 0;
    acc_im = 0;
    for (int p = 0; p < cnt; p++) begin
      ph = longint'(path_store[p].delay) * m2 - longint'(path_store[p].doppler) * n2;
      frac = ph[16:0];
      idx = ((frac + (1 << (16 - PhaseBits))) >> (17 - PhaseBits)) & ((1 << PhaseBits) - 1);
      phase_trig(idx, c, s);
      gr = path_store[p].gain_re;
      gi = path_store[p].gain_im;
      acc_re += gr * c + gi * s;
      acc_im += gi * c - gr * s;
    end
    dr = round_to_q14(acc_re) - longint'(it.observed_re);
    di = round_to_q14(acc_im) - longint'(it.observed_im);
    mag = root_nearest(longint'(dr * dr) + longint'(di * di));
    if (mag > ResMax) mag = ResMax;
    r.residual = mag[19:0];
    r.residual_index = it.pilot_index;
    return r;
  endfunction

  // update predictor for an accepted item
  function automatic void accept_item(input in_item_t it, input bit has_exp,
                                      input out_item_t exp_r);
    if (it.opcode == OpLoad) begin
      path_store[it.path_index] = {it.delay, it.doppler, it.gain_re, it.gain_im};
      loads_sent++;
    end else begin
      residual_q.push_back(has_exp ? exp_r : pilot_residual(it));
      pilots_sent++;
    end
  endfunction

  // drive one item, wait for accept, then maybe idle
  task automatic send_item(input in_item_t it, input bit has_exp, input out_item_t exp_r);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    accept_item(it, has_exp, exp_r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // wait for all residuals, let the block settle, then write the path count
  task automatic write_path_count(input logic [3:0] v);
    in_valid_i <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    path_count_q = v;
  endtask

  function automatic logic [23:0] pick_q8_16();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_q2_14();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode      = ($urandom_range(0, 9) < 4) ? OpLoad : OpPilot;
    it.path_index  = 3'($urandom());
    it.delay       = pick_q8_16();
    it.doppler     = pick_q8_16();
    it.gain_re     = pick_q2_14();
    it.gain_im     = pick_q2_14();
    it.pilot_index = 8'($urandom());
    it.pilot_m     = 8'($urandom());
    it.pilot_n     = 8'($urandom());
    it.observed_re = pick_q2_14();
    it.observed_im = pick_q2_14();
    return it;
  endfunction

  function automatic in_item_t load_item(input logic [2:0] p, input logic [23:0] dl,
                                         input logic [23:0] dp, input logic [15:0] gr,
                                         input logic [15:0] gi);
    in_item_t it;
    it = '0;
    it.opcode = OpLoad;
    it.path_index = p;
    it.delay = dl;
    it.doppler = dp;
    it.gain_re = gr;
    it.gain_im = gi;
    return it;
  endfunction

  function automatic in_item_t pilot_item(input logic [7:0] idx, input logic [7:0] m,
                                          input logic [7:0] n, input logic [15:0] ore,
                                          input logic [15:0] oim);
    in_item_t it;
    it = '0;
    it.opcode = OpPilot;
    it.pilot_index = idx;
    it.pilot_m = m;
    it.pilot_n = n;
    it.observed_re = ore;
    it.observed_im = oim;
    return it;
  endfunction

  // result checker and receiver stalls
  initial begin
    int        stall;
    out_item_t want;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        residuals_seen++;
        if (residual_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected residual %0d index %0d",
                     out_data_o.residual, out_data_o.residual_index);
        end else begin
          want = residual_q.pop_front();
          if (out_data_o.residual !== want.residual ||
              out_data_o.residual_index !== want.residual_index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("residual mismatch: expected %0d index %0d, got %0d index %0d",
                       want.residual, want.residual_index,
                       out_data_o.residual, out_data_o.residual_index);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // main sequence
  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    out_item_t none;
    logic [3:0] counts [6];
    none = '0;
    path_count_q = 4'd1;
    for (int p = 0; p < NumPaths; p++) path_store[p] = '0;

    // zero paths: residual is the magnitude of the observation
    rows.push_back('{4'd0, pilot_item(8'd0, 8'd0, 8'd0, 16'd3, 16'd4), 1'b1, '{20'd5, 8'd0}});
    rows.push_back('{NoCfg, pilot_item(8'd255, 8'd255, 8'd255, 16'h8000, 16'h8000), 1'b1,
                     '{20'd46341, 8'd255}});
    rows.push_back('{NoCfg, pilot_item(8'd17, 8'd3, 8'd9, 16'h7fff, 16'h8000), 1'b1,
                     '{20'd46340, 8'd17}});
    // unit gain at zero phase
    rows.push_back('{NoCfg, load_item(3'd0, 24'd0, 24'd0, 16'd16384, 16'd0), 1'b0, none});
    rows.push_back('{4'd1, pilot_item(8'd1, 8'd0, 8'd0, 16'd0, 16'd0), 1'b1,
                     '{20'd16384, 8'd1}});
    rows.push_back('{NoCfg, pilot_item(8'd2, 8'd255, 8'd0, 16'h7fff, 16'h7fff), 1'b0, none});
    // extreme path entries
    rows.push_back('{NoCfg, load_item(3'd1, 24'h7fffff, 24'h800000, 16'h7fff, 16'h8000), 1'b0, none});
    rows.push_back('{NoCfg, load_item(3'd2, 24'h800000, 24'h7fffff, 16'h8000, 16'h7fff), 1'b0, none});
    rows.push_back('{NoCfg, load_item(3'd3, 24'h000001, 24'hffffff, 16'h7fff, 16'h7fff), 1'b0, none});
    rows.push_back('{NoCfg, load_item(3'd4, 24'h008000, 24'h004000, 16'h8000, 16'h8000), 1'b0, none});
    rows.push_back('{NoCfg, load_item(3'd5, 24'h555555, 24'haaaaaa, 16'h5555, 16'haaaa), 1'b0, none});
    rows.push_back('{NoCfg, load_item(3'd6, 24'haaaaaa, 24'h555555, 16'haaaa, 16'h5555), 1'b0, none});
    rows.push_back('{NoCfg, load_item(3'd7, 24'h010000, 24'h020000, 16'h4000, 16'hc000), 1'b0, none});
    rows.push_back('{4'd8, pilot_item(8'd3, 8'd255, 8'd255, 16'h8000, 16'h7fff), 1'b0, none});
    rows.push_back('{NoCfg, pilot_item(8'd4, 8'd0, 8'd255, 16'd0, 16'd0), 1'b0, none});
    rows.push_back('{NoCfg, pilot_item(8'd5, 8'd255, 8'd0, 16'h7fff, 16'h8000), 1'b0, none});
    // path count beyond the store saturates
    rows.push_back('{4'd15, pilot_item(8'd6, 8'd128, 8'd127, 16'd0, 16'd0), 1'b0, none});
    rows.push_back('{NoCfg, pilot_item(8'd7, 8'd1, 8'd2, 16'h1234, 16'hedcb), 1'b0, none});
    rows.push_back('{NoCfg, load_item(3'd0, 24'h000000, 24'h000000, 16'h7fff, 16'h7fff), 1'b0, none});
    rows.push_back('{NoCfg, pilot_item(8'd8, 8'd0, 8'd0, 16'h8000, 16'h8000), 1'b0, none});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.cfg_before != NoCfg) write_path_count(4'(row.cfg_before));
      send_item(row.item, row.has_exp, row.exp);
    end

    // random phases under several path counts
    counts = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd0, 4'd6};
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 90 == 0) write_path_count(counts[n / 90]);
      if (n == NumRandom - CalmItems) calm = 1'b1;
      send_item(random_item(), 1'b0, none);
    end

    in_valid_i <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    $display("covered %0d path loads and %0d pilots, %0d residuals checked",
             loads_sent, pilots_sent, residuals_seen);
    $display("path counts 0, 1, 3, 6, 8 and 15 with random stalls on both sides");
    if (mismatches == 0 && residual_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
